// ----- src/lr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types, widths and codes of the line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

    // coordinate and configuration widths
    localparam int COORD_BITS = 13;
    localparam int CFG_BITS   = 13;
    localparam int COLOR_BITS = 24;
    localparam int ADDR_BITS  = 24;

    // walker arithmetic widths
    localparam int ADX_BITS = COORD_BITS + 1;
    localparam int NDY_BITS = COORD_BITS + 2;
    localparam int ERR_BITS = COORD_BITS + 3;

    // clipping compare and address arithmetic widths
    localparam int CMP_BITS = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;
    localparam int SUM_BITS = COORD_BITS + CFG_BITS + 1;

    // stream packing
    localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 2 * COORD_BITS + ADDR_BITS + COLOR_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // command queue
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    localparam cfg_index_t CFG_SCREEN_WIDTH  = 2'd0;
    localparam cfg_index_t CFG_SCREEN_HEIGHT = 2'd1;

    // reset values of the screen size
    localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RESET  = CFG_BITS'(1600);
    localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RESET = CFG_BITS'(1200);

    // request kinds
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [ADX_BITS-1:0]          adx_t;
    typedef logic signed [NDY_BITS-1:0]   ndy_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;
    typedef logic signed [ERR_BITS:0]     err2_t;
    typedef logic [CMP_BITS-1:0]          cmp_t;
    typedef logic [SUM_BITS-1:0]          sum_t;
    typedef logic [COLOR_BITS-1:0]        color_t;
    typedef logic [ADDR_BITS-1:0]         addr_t;
    typedef logic [CFG_BITS-1:0]          cfg_t;

    // decoded request, as it waits in the queue
    typedef struct packed {
        logic   is_step;
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        adx_t   adx;
        ndy_t   ndy;
        err_t   err;
        logic   x_neg;
        logic   y_neg;
        color_t color;
    } lr_cmd_t;

    // one emitted pixel
    typedef struct packed {
        coord_t x;
        coord_t y;
        addr_t  addr;
        logic   visible;
        color_t color;
        logic   last;
    } lr_pixel_t;

endpackage

// ----- src/lr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_front
// Accepts requests, tells loads from steps and works out the deltas,
// step directions and initial error term of a load.
// ----------------------------------------------------------------------------
module lr_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lr_pkg::IN_DATA_BITS-1:0] s_tdata,  // start_x, start_y, end_x, end_y, line_color
    input  logic                           s_tuser,  // action
    input  logic                           q_full,
    output logic                           push,
    output lr_pkg::lr_cmd_t                cmd
);
    import lr_pkg::*;

    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    ndy_t dy_ext;

    // unpack the request fields
    assign x0 = coord_t'(s_tdata[COORD_BITS-1:0]);
    assign y0 = coord_t'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
    assign x1 = coord_t'(s_tdata[3*COORD_BITS-1:2*COORD_BITS]);
    assign y1 = coord_t'(s_tdata[4*COORD_BITS-1:3*COORD_BITS]);

    // signed deltas, one bit wider than the coordinates
    assign dx     = (COORD_BITS + 1)'(x1) - (COORD_BITS + 1)'(x0);
    assign dy     = (COORD_BITS + 1)'(y1) - (COORD_BITS + 1)'(y0);
    assign dy_ext = ndy_t'(dy);

    // build the queue entry
    always_comb
    begin
        cmd.is_step = (s_tuser == ACT_STEP);
        cmd.x0      = x0;
        cmd.y0      = y0;
        cmd.x1      = x1;
        cmd.y1      = y1;
        cmd.adx     = dx[COORD_BITS] ? adx_t'(-dx) : adx_t'(dx);
        cmd.ndy     = dy[COORD_BITS] ? dy_ext : -dy_ext;
        cmd.err     = err_t'(cmd.adx) + err_t'(cmd.ndy);
        cmd.x_neg   = !(x0 < x1);
        cmd.y_neg   = !(y0 < y1);
        cmd.color   = s_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
    end

    // handshake into the queue
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

endmodule

// ----- src/lr_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_queue
// Short request queue between the front and the walker.
// ----------------------------------------------------------------------------
module lr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lr_pkg::lr_cmd_t push_cmd,
    output logic            full,
    output logic            q_valid,
    input  logic            pop,
    output lr_pkg::lr_cmd_t head_cmd
);
    import lr_pkg::*;

    lr_cmd_t                 entry_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]   wr_ptr_reg;
    logic [Q_PTR_BITS-1:0]   wr_ptr_next;
    logic [Q_PTR_BITS-1:0]   rd_ptr_reg;
    logic [Q_PTR_BITS-1:0]   rd_ptr_next;
    logic [Q_PTR_BITS:0]     count_reg;
    logic [Q_PTR_BITS:0]     count_next;
    logic                    do_push;
    logic                    do_pop;

    assign full     = (count_reg == (Q_PTR_BITS + 1)'(Q_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;
    assign head_cmd = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (Q_PTR_BITS + 1)'(Q_DEPTH))
        else $error("queue fill count beyond depth");

endmodule

// ----- src/lr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_back
// Bresenham walker: holds the line state, clips each point, forms its
// framebuffer address and drives the registered pixel output.
// ----------------------------------------------------------------------------
module lr_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  lr_pkg::lr_cmd_t          head_cmd,
    output logic                     pop,
    input  logic [lr_pkg::CFG_BITS-1:0] screen_width,
    input  logic [lr_pkg::CFG_BITS-1:0] screen_height,
    output logic                     pix_valid,
    input  logic                     pix_ready,
    output lr_pkg::lr_pixel_t        pix
);
    import lr_pkg::*;

    // walker state
    coord_t cur_x_reg;
    coord_t cur_x_next;
    coord_t cur_y_reg;
    coord_t cur_y_next;
    coord_t tgt_x_reg;
    coord_t tgt_x_next;
    coord_t tgt_y_reg;
    coord_t tgt_y_next;
    adx_t   adx_reg;
    adx_t   adx_next;
    ndy_t   ndy_reg;
    ndy_t   ndy_next;
    err_t   err_reg;
    err_t   err_next;
    logic   x_neg_reg;
    logic   x_neg_next;
    logic   y_neg_reg;
    logic   y_neg_next;
    color_t color_reg;
    color_t color_next;
    logic   active_reg;
    logic   active_next;

    // output register
    logic      out_valid_reg;
    logic      out_valid_next;
    lr_pixel_t out_reg;
    lr_pixel_t out_next;

    logic  can_issue;
    logic  emit;
    logic  vis;
    logic  fin;
    err2_t e2;
    logic  x_move;
    logic  y_move;
    sum_t  addr_sum;

    assign can_issue = !out_valid_reg || pix_ready;
    assign pop       = q_valid && can_issue;
    assign emit      = pop && head_cmd.is_step && active_reg;

    // clipping, end test and address of the current point
    always_comb
    begin
        vis = !cur_x_reg[COORD_BITS-1] && !cur_y_reg[COORD_BITS-1]
            && (cmp_t'(unsigned'(cur_x_reg)) < cmp_t'(screen_width))
            && (cmp_t'(unsigned'(cur_y_reg)) < cmp_t'(screen_height));
        fin = (cur_x_reg == tgt_x_reg) && (cur_y_reg == tgt_y_reg);
        addr_sum = sum_t'(unsigned'(cur_y_reg)) * sum_t'(screen_width)
                 + sum_t'(unsigned'(cur_x_reg));
    end

    // error term rule for the next point
    always_comb
    begin
        e2     = err2_t'(err_reg) <<< 1;
        x_move = (e2 >= err2_t'(ndy_reg));
        y_move = (e2 <= err2_t'(adx_reg));
    end

    // state and output next values
    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        tgt_x_next     = tgt_x_reg;
        tgt_y_next     = tgt_y_reg;
        adx_next       = adx_reg;
        ndy_next       = ndy_reg;
        err_next       = err_reg;
        x_neg_next     = x_neg_reg;
        y_neg_next     = y_neg_reg;
        color_next     = color_reg;
        active_next    = active_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pix_ready;

        if (pop && !head_cmd.is_step)
        begin
            // load replaces any line in progress
            cur_x_next  = head_cmd.x0;
            cur_y_next  = head_cmd.y0;
            tgt_x_next  = head_cmd.x1;
            tgt_y_next  = head_cmd.y1;
            adx_next    = head_cmd.adx;
            ndy_next    = head_cmd.ndy;
            err_next    = head_cmd.err;
            x_neg_next  = head_cmd.x_neg;
            y_neg_next  = head_cmd.y_neg;
            color_next  = head_cmd.color;
            active_next = 1'b1;
        end
        else if (emit)
        begin
            out_valid_next  = 1'b1;
            out_next.x       = cur_x_reg;
            out_next.y       = cur_y_reg;
            out_next.addr    = vis ? addr_t'(addr_sum) : '0;
            out_next.visible = vis;
            out_next.color   = color_reg;
            out_next.last    = fin;
            if (fin)
            begin
                active_next = 1'b0;
            end
            else
            begin
                err_next = err_reg + (x_move ? err_t'(ndy_reg) : err_t'(0))
                                   + (y_move ? err_t'(adx_reg) : err_t'(0));
                if (x_move)
                begin
                    cur_x_next = cur_x_reg + (x_neg_reg ? coord_t'(-1) : coord_t'(1));
                end
                if (y_move)
                begin
                    cur_y_next = cur_y_reg + (y_neg_reg ? coord_t'(-1) : coord_t'(1));
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            tgt_x_reg     <= '0;
            tgt_y_reg     <= '0;
            adx_reg       <= '0;
            ndy_reg       <= '0;
            err_reg       <= '0;
            x_neg_reg     <= 1'b0;
            y_neg_reg     <= 1'b0;
            color_reg     <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            tgt_x_reg     <= tgt_x_next;
            tgt_y_reg     <= tgt_y_next;
            adx_reg       <= adx_next;
            ndy_reg       <= ndy_next;
            err_reg       <= err_next;
            x_neg_reg     <= x_neg_next;
            y_neg_reg     <= y_neg_next;
            color_reg     <= color_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign pix_valid = out_valid_reg;
    assign pix       = out_reg;

    // the end point disarms the walker
    a_last_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && fin) |=> !active_reg)
        else $error("walker still armed after last pixel");

    // a point that is not the end point is followed by a different one
    a_point_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !fin) |=> (cur_x_reg != $past(cur_x_reg)) || (cur_y_reg != $past(cur_y_reg)))
        else $error("walker did not move");

    // the point holds while no request is taken
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !pop |=> $stable(cur_x_reg) && $stable(cur_y_reg) && $stable(err_reg))
        else $error("walker state changed without a request");

    // a clipped pixel carries a zero address
    a_clip_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.visible) |-> (out_reg.addr == '0))
        else $error("clipped pixel with nonzero address");

endmodule

// ----- src/line_rasterizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer
// All-octant Bresenham line walker with screen clipping and framebuffer
// address generation.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  load or step request
//  m_*       out        m_tvalid / m_tready  one pixel per step of an armed line
//  cfg_*     in         cfg_valid / cfg_ready screen width (0), screen height (1)
//
//  one request per clock while the queue is not full; a step is registered in
//  the queue, then the walker writes its pixel into the output register; the walk
//  loop and the width multiply are both combinational in the walker
//  a stalled output holds its pixel, the two-entry queue fills, then s_tready drops
//  reset disarms the walker and sets the screen to 1600 x 1200; no clearing pass
// ----------------------------------------------------------------------------
module line_rasterizer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lr_pkg::IN_DATA_BITS-1:0]  s_tdata,   // start_x, start_y, end_x, end_y, line_color, zero fill
    input  logic                             s_tuser,   // action
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lr_pkg::OUT_DATA_BITS-1:0] m_tdata,   // pixel_x, pixel_y, pixel_address, pixel_color, zero fill
    output logic                             m_tuser,   // visible
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  lr_pkg::cfg_index_t               cfg_index,
    input  logic [lr_pkg::CFG_BITS-1:0]      cfg_data
);
    import lr_pkg::*;

    cfg_t      width_reg;
    cfg_t      width_next;
    cfg_t      height_reg;
    cfg_t      height_next;
    logic      push;
    logic      q_full;
    logic      q_valid;
    logic      pop;
    lr_cmd_t   push_cmd;
    lr_cmd_t   head_cmd;
    lr_pixel_t pix;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  width_next  = cfg_data;
                CFG_SCREEN_HEIGHT: height_next = cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_WIDTH_RESET;
            height_reg <= SCREEN_HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // request decode
    lr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    // queue between decode and walker
    lr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .q_valid  (q_valid),
        .pop      (pop),
        .head_cmd (head_cmd)
    );

    // walker and pixel output
    lr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .pix_valid     (m_tvalid),
        .pix_ready     (m_tready),
        .pix           (pix)
    );

    // pack the pixel
    assign m_tdata = OUT_DATA_BITS'({pix.color, pix.addr, pix.y, pix.x});
    assign m_tuser = pix.visible;
    assign m_tlast = pix.last;

endmodule
